@@ rtl/wcc_pkg.sv @@
package wcc_pkg;

  localparam int unsigned MAX_WINDOW_PIXELS_DEF = 1024;
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned FRAC_SHIFT = 30;
  localparam logic [COEF_W-1:0] THRESHOLD_RESET = 16'd32440;
  localparam logic [COEF_W-1:0] COEF_MAX = 16'h7fff;

  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,
    OP_SX_SX  = 3'd1,
    OP_N_SYY  = 3'd2,
    OP_SY_SY  = 3'd3,
    OP_N_SXY  = 3'd4,
    OP_SX_SY  = 3'd5,
    OP_MAG_SQ = 3'd6,
    OP_VX_VY  = 3'd7
  } op_t;

  typedef struct packed {
    logic acc;
    logic mul_load;
    logic mul_step;
    logic mul_store;
    logic root_init;
    logic root_step;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

@@ rtl/wcc_pixel_if.sv @@
interface wcc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] window_pixel;
  logic [7:0] template_pixel;
  logic       last_pixel;

  modport source (output valid, window_pixel, template_pixel, last_pixel, input ready);
  modport sink (input valid, window_pixel, template_pixel, last_pixel, output ready);
endinterface

@@ rtl/wcc_result_if.sv @@
interface wcc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coefficient;
  logic               match;
  logic               degenerate;
  logic               overflow;

  modport source (output valid, coefficient, match, degenerate, overflow, input ready);
  modport sink (input valid, coefficient, match, degenerate, overflow, output ready);
endinterface

@@ rtl/wcc_cfg_if.sv @@
interface wcc_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] match_threshold;

  modport source (output valid, match_threshold, input ready);
  modport sink (input valid, match_threshold, output ready);
endinterface

@@ rtl/window_correlation_coefficient.sv @@
// After the last pixel pair, one shift-add multiplier forms the eight products of the final step
//   in turn; the square root then runs, and the result waits for a free output register.
// Throughput: one pixel pair per cycle within a window; the next window's first pair
//   is taken once the result is in the output register.
// Reset (rst, synchronous): accumulators clear, no result pending, threshold 32440.
module window_correlation_coefficient #(
  parameter int unsigned MAX_WINDOW_PIXELS = wcc_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input logic           clk,
  input logic           rst,
  wcc_pixel_if.sink     pixel,
  wcc_result_if.source  result,
  wcc_cfg_if.sink       cfg
);
  import wcc_pkg::*;

  localparam int unsigned N_W   = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int unsigned MUL_W = 2 * N_W + 2 * PIXEL_W;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  wcc_ctrl #(
    .MUL_W(MUL_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(pixel.valid),
    .in_last (pixel.last_pixel),
    .in_ready(pixel.ready),
    .status  (status),
    .cmd     (cmd)
  );

  wcc_datapath #(
    .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .window_pixel  (pixel.window_pixel),
    .template_pixel(pixel.template_pixel),
    .cfg_valid     (cfg.valid),
    .cfg_threshold (cfg.match_threshold),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .coefficient   (result.coefficient),
    .match         (result.match),
    .degenerate    (result.degenerate),
    .overflow      (result.overflow)
  );

endmodule

@@ rtl/wcc_ctrl.sv @@
module wcc_ctrl #(
  parameter int unsigned MUL_W = 38
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  wcc_pkg::status_t status,
  output wcc_pkg::cmd_t   cmd
);
  import wcc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_W);

  typedef enum logic [6:0] {
    S_ACC   = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_STORE = 7'b0001000,
    S_RINIT = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.op     = op;
    in_ready   = 1'b0;
    case (state)
      S_ACC: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
        if (in_valid && in_last) begin
          op_next    = OP_N_SXX;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.mul_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(MUL_W - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.mul_store = 1'b1;
        if (op == OP_VX_VY) begin
          state_next = S_RINIT;
        end else begin
          op_next    = op_t'(op + 3'd1);
          state_next = S_LOAD;
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      op    <= OP_N_SXX;
      cnt   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/wcc_datapath.sv @@
module wcc_datapath #(
  parameter int unsigned MAX_WINDOW_PIXELS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  wcc_pkg::cmd_t            cmd,
  output wcc_pkg::status_t         status,
  input  logic [7:0]               window_pixel,
  input  logic [7:0]               template_pixel,
  input  logic                     cfg_valid,
  input  logic signed [15:0]       cfg_threshold,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       coefficient,
  output logic                     match,
  output logic                     degenerate,
  output logic                     overflow
);
  import wcc_pkg::*;

  localparam int unsigned N_W   = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int unsigned S_W   = N_W + PIXEL_W;
  localparam int unsigned SQ_W  = N_W + 2 * PIXEL_W;
  localparam int unsigned MUL_W = 2 * N_W + 2 * PIXEL_W;
  localparam int unsigned P_W   = 2 * MUL_W;
  localparam int unsigned C_W   = P_W + FRAC_SHIFT + 3;

  logic [N_W-1:0]  pair_count;
  logic [S_W-1:0]  sum_window, sum_template;
  logic [SQ_W-1:0] sumsq_window, sumsq_template, sum_cross;
  logic            overflow_seen;
  logic signed [15:0] match_threshold;

  logic [P_W-1:0]   mul_acc, mul_mcand;
  logic [MUL_W-1:0] mul_mplier;
  logic [MUL_W-1:0] opa, opb;

  logic [MUL_W-1:0] tmp, vx, vy, pa, mag;
  logic [P_W-1:0]   m2, dd;
  logic             neg;

  logic [C_W-1:0] root_p, root_f, root_e, rhs, trial;
  logic [15:0]    q;
  logic           fits, deg;
  logic signed [15:0] coef;

  always_comb begin
    case (cmd.op)
      OP_N_SXX:  begin opa = MUL_W'(pair_count);   opb = MUL_W'(sumsq_window);   end
      OP_SX_SX:  begin opa = MUL_W'(sum_window);   opb = MUL_W'(sum_window);     end
      OP_N_SYY:  begin opa = MUL_W'(pair_count);   opb = MUL_W'(sumsq_template); end
      OP_SY_SY:  begin opa = MUL_W'(sum_template); opb = MUL_W'(sum_template);   end
      OP_N_SXY:  begin opa = MUL_W'(pair_count);   opb = MUL_W'(sum_cross);      end
      OP_SX_SY:  begin opa = MUL_W'(sum_window);   opb = MUL_W'(sum_template);   end
      OP_MAG_SQ: begin opa = mag;                  opb = mag;                    end
      OP_VX_VY:  begin opa = vx;                   opb = vy;                     end
      default:   begin opa = '0;                   opb = '0;                     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_acc    <= '0;
      mul_mcand  <= P_W'(opa);
      mul_mplier <= opb;
    end else if (cmd.mul_step) begin
      if (mul_mplier[0]) begin
        mul_acc <= mul_acc + mul_mcand;
      end
      mul_mcand  <= mul_mcand << 1;
      mul_mplier <= mul_mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_store) begin
      case (cmd.op)
        OP_N_SXX:  tmp <= mul_acc[MUL_W-1:0];
        OP_SX_SX:  vx  <= tmp - mul_acc[MUL_W-1:0];
        OP_N_SYY:  tmp <= mul_acc[MUL_W-1:0];
        OP_SY_SY:  vy  <= tmp - mul_acc[MUL_W-1:0];
        OP_N_SXY:  pa  <= mul_acc[MUL_W-1:0];
        OP_SX_SY: begin
          neg <= pa < mul_acc[MUL_W-1:0];
          mag <= (pa < mul_acc[MUL_W-1:0]) ? mul_acc[MUL_W-1:0] - pa
                                           : pa - mul_acc[MUL_W-1:0];
        end
        OP_MAG_SQ: m2 <= mul_acc;
        OP_VX_VY:  dd <= mul_acc;
        default: ;
      endcase
    end
  end

  // greedy root: largest q with q^2 * vx * vy <= mag^2 * 2^30
  assign rhs   = C_W'({m2, FRAC_SHIFT'(0)});
  assign trial = root_p + root_f + root_e;
  assign fits  = trial <= rhs;

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      root_p <= '0;
      root_f <= '0;
      root_e <= C_W'({dd, FRAC_SHIFT'(0)});
      q      <= '0;
    end else if (cmd.root_step) begin
      q      <= {q[14:0], fits};
      root_e <= root_e >> 2;
      if (fits) begin
        root_p <= trial;
        root_f <= (root_f >> 1) + root_e;
      end else begin
        root_f <= root_f >> 1;
      end
    end
  end

  assign deg = (vx == '0) || (vy == '0);

  always_comb begin
    if (deg) begin
      coef = '0;
    end else if (neg) begin
      coef = -$signed(q);
    end else if (q[15]) begin
      coef = $signed(COEF_MAX);
    end else begin
      coef = $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count    <= '0;
      sum_window    <= '0;
      sum_template  <= '0;
      sumsq_window  <= '0;
      sumsq_template <= '0;
      sum_cross     <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.finish) begin
      pair_count    <= '0;
      sum_window    <= '0;
      sum_template  <= '0;
      sumsq_window  <= '0;
      sumsq_template <= '0;
      sum_cross     <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.acc) begin
      if (pair_count == N_W'(MAX_WINDOW_PIXELS)) begin
        overflow_seen <= 1'b1;
      end else begin
        pair_count     <= pair_count + 1'b1;
        sum_window     <= sum_window + S_W'(window_pixel);
        sum_template   <= sum_template + S_W'(template_pixel);
        sumsq_window   <= sumsq_window + SQ_W'(window_pixel * window_pixel);
        sumsq_template <= sumsq_template + SQ_W'(template_pixel * template_pixel);
        sum_cross      <= sum_cross + SQ_W'(window_pixel * template_pixel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= $signed(THRESHOLD_RESET);
    end else if (cfg_valid) begin
      match_threshold <= cfg_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      coefficient <= coef;
      match       <= !deg && (coef >= match_threshold);
      degenerate  <= deg;
      overflow    <= overflow_seen;
    end
  end

  assign status.out_full = out_valid && !out_ready;

endmodule

@@ rtl/wcc_checker.sv @@
module wcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_ready,
  input logic        pixel_last,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] coefficient,
  input logic        match,
  input logic        degenerate
);

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |-> coefficient == 16'd0 && !match)
    else $error("degenerate result with nonzero coefficient or match");

  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && pixel_last |=> !pixel_ready)
    else $error("input taken while result computation runs");

  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind window_correlation_coefficient wcc_checker u_wcc_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .pixel_last  (pixel.last_pixel),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .coefficient (result.coefficient),
  .match       (result.match),
  .degenerate  (result.degenerate)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import wcc_pkg::*;

  typedef struct {
    logic signed [15:0] coef;
    logic               match;
    logic               degen;
    logic               ovf;
  } corr_res_t;

  typedef struct {
    bit [7:0]           w;
    bit [7:0]           t;
    bit                 l;
    bit                 typed;
    logic signed [15:0] coef;
    bit                 match;
    bit                 degen;
    bit                 ovf;
  } pair_row_t;

  localparam int unsigned CAPACITY = MAX_WINDOW_PIXELS_DEF;
  localparam int unsigned LATENCY = 8 * (2 * $clog2(CAPACITY + 1) + 18) + 20;
  localparam int unsigned STALL_LIMIT = 4000;

  logic clk;
  logic rst;

  wcc_pixel_if  pix();
  wcc_result_if res();
  wcc_cfg_if    cfg_ch();

  window_correlation_coefficient u_top (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix),
    .result(res),
    .cfg   (cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // window accumulators
  longint unsigned    acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy;
  bit                 acc_ovf;
  logic signed [15:0] thr_m;
  corr_res_t          corr_q[$];
  pair_row_t          typed_q[$];
  int                 errors;
  bit                 quiet;
  int                 src_items;

  function automatic logic signed [15:0] pearson_q15(
    longint unsigned n, longint unsigned sx, longint unsigned sy, longint unsigned sxx,
    longint unsigned syy, longint unsigned sxy, output bit degen);
    longint unsigned vx, vy, pa, pb, mag, lo, hi, mid;
    logic [127:0]    d, rhs;
    bit              neg;
    vx = n * sxx - sx * sx;
    vy = n * syy - sy * sy;
    pa = n * sxy;
    pb = sx * sy;
    neg = pa < pb;
    mag = neg ? pb - pa : pa - pb;
    degen = (vx == 0) || (vy == 0);
    if (degen) return 16'sd0;
    d = 128'(vx) * 128'(vy);
    rhs = (128'(mag) * 128'(mag)) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (d * 128'(mid * mid) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) return -$signed(17'(lo));
    return (lo > 32767) ? 16'sd32767 : 16'(lo);
  endfunction

  task automatic take_pair(bit [7:0] w, bit [7:0] t, bit l);
    corr_res_t e;
    pair_row_t row;
    bit        degen;
    if (acc_n >= CAPACITY) begin
      acc_ovf = 1'b1;
    end else begin
      acc_sx += w;
      acc_sy += t;
      acc_sxx += w * w;
      acc_syy += t * t;
      acc_sxy += w * t;
      acc_n++;
    end
    if (!l) return;
    e.coef = pearson_q15(acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy, degen);
    e.degen = degen;
    e.match = !degen && (e.coef >= thr_m);
    e.ovf = acc_ovf;
    row = typed_q.pop_front();
    if (row.typed) begin
      e.coef = row.coef;
      e.match = row.match;
      e.degen = row.degen;
      e.ovf = row.ovf;
    end
    corr_q.push_back(e);
    {acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy} = '0;
    acc_ovf = 1'b0;
  endtask

  task automatic check_result();
    corr_res_t e;
    if (corr_q.size() == 0) begin
      $display("%0t unexpected result coef %0d", $time, res.coefficient);
      errors++;
      return;
    end
    e = corr_q.pop_front();
    if (res.coefficient !== e.coef) begin
      $display("%0t coefficient exp %0d got %0d", $time, e.coef, res.coefficient);
      errors++;
    end
    if (res.match !== e.match) begin
      $display("%0t match exp %0b got %0b", $time, e.match, res.match);
      errors++;
    end
    if (res.degenerate !== e.degen) begin
      $display("%0t degenerate exp %0b got %0b", $time, e.degen, res.degenerate);
      errors++;
    end
    if (res.overflow !== e.ovf) begin
      $display("%0t overflow exp %0b got %0b", $time, e.ovf, res.overflow);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      {acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy} = '0;
      acc_ovf = 1'b0;
      thr_m = THRESHOLD_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) thr_m = cfg_ch.match_threshold;
      if (pix.valid && pix.ready)
        take_pair(pix.window_pixel, pix.template_pixel, pix.last_pixel);
      if (res.valid && res.ready) check_result();
    end
  end

  // result back-pressure
  int stall_left;
  always @(posedge clk) begin
    if (rst || quiet) begin
      res.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      res.ready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      res.ready <= 1'b1;
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pair(bit [7:0] w, bit [7:0] t, bit l);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.window_pixel <= w;
    pix.template_pixel <= t;
    pix.last_pixel <= l;
    do @(posedge clk); while (!pix.ready);
    src_items++;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    wait (corr_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [15:0] thr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.match_threshold <= thr;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [7:0] near(int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  task automatic send_window(int len, int mode);
    pair_row_t row;
    bit [7:0]  w, t;
    int        noise;
    row = '{default: 0};
    typed_q.push_back(row);
    noise = $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      w = $urandom_range(0, 255);
      case (mode)
        0: t = $urandom_range(0, 255);
        1: t = near(int'(w) + $urandom_range(0, 2 * noise) - noise);
        default: t = near(255 - int'(w) + $urandom_range(0, 2 * noise) - noise);
      endcase
      send_pair(w, t, i == len - 1);
    end
  endtask

  task automatic random_phase(int count);
    int start, len;
    start = src_items;
    while (src_items - start < count) begin
      case ($urandom_range(0, 19))
        0: len = 1;
        1: len = $urandom_range(20, 60);
        default: len = $urandom_range(2, 12);
      endcase
      send_window(len, $urandom_range(0, 2));
    end
  endtask

  pair_row_t dir_rows[] = '{
    '{8'd0,   8'd0,   1'b1, 1'b1, 16'sd0,      1'b0, 1'b1, 1'b0},
    '{8'd0,   8'd0,   1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd255, 1'b1, 1'b1, 16'sd32767,  1'b1, 1'b0, 1'b0},
    '{8'd0,   8'd255, 1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd0,   1'b1, 1'b1, -16'sd32768, 1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd0,   1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd200, 1'b1, 1'b1, 16'sd0,      1'b0, 1'b1, 1'b0},
    '{8'd7,   8'd9,   1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd200, 8'd9,   1'b1, 1'b1, 16'sd0,      1'b0, 1'b1, 1'b0},
    '{8'd10,  8'd200, 1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd100, 8'd30,  1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd250, 8'd90,  1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd128, 8'd255, 1'b1, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd255, 1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd1,   8'd254, 1'b0, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0},
    '{8'd128, 8'd127, 1'b1, 1'b0, 16'sd0,      1'b0, 1'b0, 1'b0}
  };

  initial begin
    errors = 0;
    quiet = 1'b0;
    src_items = 0;
    rst <= 1'b1;
    pix.valid <= 1'b0;
    pix.window_pixel <= '0;
    pix.template_pixel <= '0;
    pix.last_pixel <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.match_threshold <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].l) typed_q.push_back(dir_rows[i]);
      send_pair(dir_rows[i].w, dir_rows[i].t, dir_rows[i].l);
    end
    drain();

    write_threshold(16'sd32767);
    random_phase(100);
    drain();

    write_threshold(-16'sd32768);
    random_phase(80);
    send_window(CAPACITY + 6, 1);
    drain();

    write_threshold(16'sd0);
    random_phase(100);
    drain();

    write_threshold($signed(16'($urandom_range(0, 65535))));
    random_phase(100);
    drain();

    write_threshold(16'sd32440);
    quiet = 1'b1;
    random_phase(100);
    drain();

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wcc_pkg.sv
rtl/wcc_pixel_if.sv
rtl/wcc_result_if.sv
rtl/wcc_cfg_if.sv
rtl/wcc_ctrl.sv
rtl/wcc_datapath.sv
rtl/window_correlation_coefficient.sv
rtl/wcc_checker.sv
tb/tb.sv
